FILE: hw/rtl/isaac_pkg.sv
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared types and constants for the ISAAC generator and its key mixer.
// ----------------------------------------------------------------------------
package isaac_pkg;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    // request kinds
    localparam logic [1:0] KIND_DRAW      = 2'd0;
    localparam logic [1:0] KIND_LOAD      = 2'd1;
    localparam logic [1:0] KIND_INIT      = 2'd2;
    localparam logic [1:0] KIND_INIT_ZERO = 2'd3;

    // control from the sequencer to the key mixer
    typedef struct packed {
        logic        init;   // load all eight words with the golden ratio
        logic        add;    // word[sel] += data
        logic        step;   // one scramble line, line number sel
        logic [2:0]  sel;
        logic [31:0] data;
    } t_mix_ctl;

    // shift applied on each scramble line
    function automatic logic [31:0] mix_shift(input logic [2:0] line, input logic [31:0] v);
        logic [31:0] res;
        case (line)
            3'd0:    res = v << 11;
            3'd1:    res = v >> 2;
            3'd2:    res = v << 8;
            3'd3:    res = v >> 16;
            3'd4:    res = v << 10;
            3'd5:    res = v >> 4;
            3'd6:    res = v << 8;
            default: res = v >> 9;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/isaac_random_generator.sv
// ----------------------------------------------------------------------------
// isaac_random_generator
// ISAAC 32-bit generator built around the result and mix memories.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries requests: draw, load a seed word,
// init from the loaded seed, init from an all-zero seed. Only a draw yields
// an output on o_valid / o_random_word; the output register holds a word
// while i_stall is high, and the next request may be taken meanwhile.
// One request is worked on at a time; o_stall is high while busy.
//   load:  the seed word is written into the result memory while idle.
//   draw:  a result memory read, then the output register is loaded once
//          it is free, while words remain in the table.
//   regeneration: states RG1, RG2, RG3 for each word, set by the three
//          dependent mix memory reads (entry, indirect, second indirect).
//   init:  golden-ratio load, scramble rounds, then two key passes over
//          blocks of eight words (read/add, scramble, write per block),
//          then one regeneration; zero-seed init first clears the result memory.
// After reset both memories are cleared, one entry per cycle, before the
// first request is taken. The first draw after reset regenerates from
// the cleared state.
// ----------------------------------------------------------------------------
module isaac_random_generator import isaac_pkg::*; #(
    parameter int TABLE_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_seed_index,
    input  logic [31:0] i_seed_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word
);

    localparam int IDX_W = $clog2(TABLE_WORDS);
    localparam int WL_W  = IDX_W + 1;
    localparam int SHIFT = IDX_W + 2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(TABLE_WORDS / 2);
    localparam logic [IDX_W-1:0] BASE_END = IDX_W'(TABLE_WORDS - 8);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DRAW_RD  = 4'd2;
    localparam logic [3:0] ST_DRAW     = 4'd3;
    localparam logic [3:0] ST_ZERO     = 4'd4;
    localparam logic [3:0] ST_KS_INIT  = 4'd5;
    localparam logic [3:0] ST_KS_RND   = 4'd6;
    localparam logic [3:0] ST_KS_RD    = 4'd7;
    localparam logic [3:0] ST_KS_SCR   = 4'd8;
    localparam logic [3:0] ST_KS_WR    = 4'd9;
    localparam logic [3:0] ST_RG_START = 4'd10;
    localparam logic [3:0] ST_RG1      = 4'd11;
    localparam logic [3:0] ST_RG2      = 4'd12;
    localparam logic [3:0] ST_RG3      = 4'd13;

    function automatic logic [31:0] gen_shift(input logic [1:0] phase, input logic [31:0] a);
        logic [31:0] res;
        case (phase)
            2'd0:    res = a << 13;
            2'd1:    res = a >> 6;
            2'd2:    res = a << 2;
            default: res = a >> 16;
        endcase
        return res;
    endfunction

    // memories
    logic [31:0] r_mix_mem [TABLE_WORDS];
    logic [31:0] r_res_mem [TABLE_WORDS];
    logic [31:0] r_mix_rd_a;
    logic [31:0] r_mix_rd_b;
    logic [31:0] r_res_rd;

    logic             mix_we;
    logic [IDX_W-1:0] mix_wa;
    logic [31:0]      mix_wd;
    logic [IDX_W-1:0] mix_ra_a;
    logic [IDX_W-1:0] mix_ra_b;
    logic             res_we;
    logic [IDX_W-1:0] res_wa;
    logic [31:0]      res_wd;
    logic             res_re;
    logic [IDX_W-1:0] res_ra;

    // control and datapath registers
    logic [3:0]       r_state,      n_state;
    logic [IDX_W-1:0] r_i,          n_i;
    logic [IDX_W-1:0] r_base,       n_base;
    logic [3:0]       r_cnt,        n_cnt;
    logic [2:0]       r_sel,        n_sel;
    logic [1:0]       r_round,      n_round;
    logic             r_pass,       n_pass;
    logic             r_draw,       n_draw;
    logic [31:0]      r_acc_a,      n_acc_a;
    logic [31:0]      r_acc_b,      n_acc_b;
    logic [31:0]      r_gen_cnt,    n_gen_cnt;
    logic [WL_W-1:0]  r_words_left, n_words_left;
    logic [31:0]      r_x,          n_x;
    logic [31:0]      r_y,          n_y;
    logic             r_fwd,        n_fwd;
    logic             r_out_valid,  n_out_valid;
    logic [31:0]      r_out_word,   n_out_word;

    t_mix_ctl         mix_ctl;
    logic [31:0]      mix_word;
    logic             accept;
    logic [31:0]      gen_next;
    logic [31:0]      y_sum;
    logic [IDX_W-1:0] y_idx;
    logic [31:0]      b_sum;

    isaac_mixer u_mixer (
        .i_clk  (i_clk),
        .i_ctl  (mix_ctl),
        .o_word (mix_word)
    );

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign gen_next = r_gen_cnt + 32'd1;
    assign y_sum    = r_mix_rd_a + r_acc_a + r_acc_b;
    assign y_idx    = y_sum[SHIFT +: IDX_W];
    // second lookup may hit the entry written in the same cycle
    assign b_sum    = (r_fwd ? r_y : r_mix_rd_a) + r_x;

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_sel        = r_sel;
        n_round      = r_round;
        n_pass       = r_pass;
        n_draw       = r_draw;
        n_acc_a      = r_acc_a;
        n_acc_b      = r_acc_b;
        n_gen_cnt    = r_gen_cnt;
        n_words_left = r_words_left;
        n_x          = r_x;
        n_y          = r_y;
        n_fwd        = r_fwd;
        n_out_valid  = r_out_valid && i_stall;
        n_out_word   = r_out_word;

        mix_we   = 1'b0;
        mix_wa   = r_i;
        mix_wd   = '0;
        mix_ra_a = r_i;
        mix_ra_b = r_i + IDX_HALF;
        res_we   = 1'b0;
        res_wa   = r_i;
        res_wd   = '0;
        res_re   = 1'b0;
        res_ra   = r_words_left[IDX_W-1:0];

        mix_ctl      = '0;
        mix_ctl.sel  = r_sel;
        mix_ctl.data = r_res_rd;

        case (r_state)
            ST_CLEAR: begin
                mix_we = 1'b1;
                res_we = 1'b1;
                n_i    = r_i + 1'b1;
                if (r_i == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_DRAW: begin
                            if (r_words_left == '0) begin
                                n_draw  = 1'b1;
                                n_i     = '0;
                                n_state = ST_RG_START;
                            end else begin
                                n_words_left = r_words_left - 1'b1;
                                n_state      = ST_DRAW_RD;
                            end
                        end
                        KIND_LOAD: begin
                            res_we = 1'b1;
                            res_wa = IDX_W'(i_seed_index);
                            res_wd = i_seed_word;
                        end
                        KIND_INIT: begin
                            n_state = ST_KS_INIT;
                        end
                        KIND_INIT_ZERO: begin
                            n_i     = '0;
                            n_state = ST_ZERO;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW_RD: begin
                res_re  = 1'b1;
                n_state = ST_DRAW;
            end
            ST_DRAW: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res_rd;
                    n_state     = ST_IDLE;
                end
            end
            ST_ZERO: begin
                res_we = 1'b1;
                n_i    = r_i + 1'b1;
                if (r_i == IDX_LAST) begin
                    n_state = ST_KS_INIT;
                end
            end
            ST_KS_INIT: begin
                mix_ctl.init = 1'b1;
                n_acc_a      = '0;
                n_acc_b      = '0;
                n_gen_cnt    = '0;
                n_sel        = '0;
                n_round      = '0;
                n_state      = ST_KS_RND;
            end
            ST_KS_RND: begin
                mix_ctl.step = 1'b1;
                n_sel        = r_sel + 1'b1;
                if (r_sel == 3'd7) begin
                    n_round = r_round + 1'b1;
                    if (r_round == 2'd3) begin
                        n_base  = '0;
                        n_cnt   = '0;
                        n_pass  = 1'b0;
                        n_state = ST_KS_RD;
                    end
                end
            end
            ST_KS_RD: begin
                // read eight words, add each into the mixer in the following cycle
                mix_ra_a = r_base + IDX_W'(r_cnt[2:0]);
                res_ra   = r_base + IDX_W'(r_cnt[2:0]);
                res_re   = !r_pass && !r_cnt[3];
                if (r_cnt != 4'd0) begin
                    mix_ctl.add  = 1'b1;
                    mix_ctl.sel  = r_cnt[2:0] - 3'd1;
                    mix_ctl.data = r_pass ? r_mix_rd_a : r_res_rd;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3]) begin
                    n_cnt   = '0;
                    n_sel   = '0;
                    n_state = ST_KS_SCR;
                end
            end
            ST_KS_SCR: begin
                mix_ctl.step = 1'b1;
                n_sel        = r_sel + 1'b1;
                if (r_sel == 3'd7) begin
                    n_state = ST_KS_WR;
                end
            end
            ST_KS_WR: begin
                mix_we = 1'b1;
                mix_wa = r_base + IDX_W'(r_sel);
                mix_wd = mix_word;
                n_sel  = r_sel + 1'b1;
                if (r_sel == 3'd7) begin
                    if (r_base == BASE_END) begin
                        n_base = '0;
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_state = ST_KS_RD;
                        end else begin
                            n_draw  = 1'b0;
                            n_i     = '0;
                            n_state = ST_RG_START;
                        end
                    end else begin
                        n_base  = r_base + IDX_W'(8);
                        n_state = ST_KS_RD;
                    end
                end
            end
            ST_RG_START: begin
                n_gen_cnt = gen_next;
                n_acc_b   = r_acc_b + gen_next;
                n_state   = ST_RG1;
            end
            ST_RG1: begin
                n_x      = r_mix_rd_a;
                n_acc_a  = (r_acc_a ^ gen_shift(r_i[1:0], r_acc_a)) + r_mix_rd_b;
                mix_ra_a = r_mix_rd_a[2 +: IDX_W];
                n_state  = ST_RG2;
            end
            ST_RG2: begin
                mix_we   = 1'b1;
                mix_wd   = y_sum;
                mix_ra_a = y_idx;
                n_fwd    = (y_idx == r_i);
                n_y      = y_sum;
                n_state  = ST_RG3;
            end
            ST_RG3: begin
                n_acc_b = b_sum;
                res_we  = 1'b1;
                res_wd  = b_sum;
                if (r_i == IDX_LAST) begin
                    n_i = '0;
                    if (r_draw) begin
                        n_words_left = WL_W'(TABLE_WORDS - 1);
                        n_state      = ST_DRAW_RD;
                    end else begin
                        n_words_left = WL_W'(TABLE_WORDS);
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_i      = r_i + 1'b1;
                    mix_ra_a = r_i + 1'b1;
                    mix_ra_b = r_i + 1'b1 + IDX_HALF;
                    n_state  = ST_RG1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_i          <= '0;
            r_base       <= '0;
            r_cnt        <= '0;
            r_sel        <= '0;
            r_round      <= '0;
            r_pass       <= 1'b0;
            r_draw       <= 1'b0;
            r_acc_a      <= '0;
            r_acc_b      <= '0;
            r_gen_cnt    <= '0;
            r_words_left <= '0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_base       <= n_base;
            r_cnt        <= n_cnt;
            r_sel        <= n_sel;
            r_round      <= n_round;
            r_pass       <= n_pass;
            r_draw       <= n_draw;
            r_acc_a      <= n_acc_a;
            r_acc_b      <= n_acc_b;
            r_gen_cnt    <= n_gen_cnt;
            r_words_left <= n_words_left;
            r_fwd        <= n_fwd;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (mix_we) begin
            r_mix_mem[mix_wa] <= mix_wd;
        end
        r_mix_rd_a <= r_mix_mem[mix_ra_a];
        r_mix_rd_b <= r_mix_mem[mix_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res_mem[res_wa] <= res_wd;
        end
        if (res_re) begin
            r_res_rd <= r_res_mem[res_ra];
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

endmodule

FILE: hw/rtl/isaac_mixer.sv
// ----------------------------------------------------------------------------
// isaac_mixer
// Eight-word state of the key schedule; one scramble line per cycle while step is set.
// ----------------------------------------------------------------------------
module isaac_mixer import isaac_pkg::*; (
    input  logic        i_clk,
    input  t_mix_ctl    i_ctl,
    output logic [31:0] o_word
);

    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [2:0]  k1;
    logic [2:0]  k2;
    logic [2:0]  k3;
    logic [31:0] t_new;

    assign k1    = i_ctl.sel + 3'd1;
    assign k2    = i_ctl.sel + 3'd2;
    assign k3    = i_ctl.sel + 3'd3;
    assign t_new = r_v[i_ctl.sel] ^ mix_shift(i_ctl.sel, r_v[k1]);

    always_comb begin
        n_v = r_v;
        if (i_ctl.init) begin
            for (int k = 0; k < 8; k++) begin
                n_v[k] = GOLDEN;
            end
        end else if (i_ctl.add) begin
            n_v[i_ctl.sel] = r_v[i_ctl.sel] + i_ctl.data;
        end else if (i_ctl.step) begin
            // v[k] ^= shift(v[k+1]); v[k+3] += v[k]; v[k+1] += v[k+2]
            n_v[i_ctl.sel] = t_new;
            n_v[k3]        = r_v[k3] + t_new;
            n_v[k1]        = r_v[k1] + r_v[k2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_word = r_v[i_ctl.sel];

endmodule
